// File: hw/rtl/mhpq_pkg.sv
package mhpq_pkg;
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_INCR   = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_KEY_LOWER = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_DEL_RD,
        S_DEL_LD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_WR,
        S_COPY,
        S_EM_RD0,
        S_EM_RDL,
        S_EM_OUT,
        S_RESULT
    } t_state;
endpackage

// File: hw/rtl/mhpq_if.sv
interface mhpq_req_if #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [ID_BITS-1:0]  item_id;
    logic [KEY_BITS-1:0] item_key;
    modport source (output valid, action, item_id, item_key, input ready);
    modport sink   (input valid, action, item_id, item_key, output ready);
endinterface

interface mhpq_rsp_if #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ID_BITS-1:0]  out_id;
    logic [KEY_BITS-1:0] out_key;
    logic                out_valid;
    logic [5:0]          entry_count;
    logic                last;
    modport source (output valid, status, out_id, out_key, out_valid, entry_count, last,
                    input ready);
    modport sink   (input valid, status, out_id, out_key, out_valid, entry_count, last,
                    output ready);
endinterface

// File: hw/rtl/mhpq_front.sv
module mhpq_front #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32,
    parameter int QW       = 2 + ID_BITS + KEY_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mhpq_req_if.sink      req,
    output logic          o_q_valid,
    output logic [QW-1:0] o_q_data,
    input  logic          i_q_pop
);
    import mhpq_pkg::*;

    logic [QW-1:0] r_buf [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign req.ready = (r_cnt != 2'd2);
    assign push      = req.valid && req.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= {req.action, req.item_id, req.item_key};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: hw/rtl/mhpq_back.sv
module mhpq_back #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32,
    parameter int QW       = 2 + ID_BITS + KEY_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [QW-1:0] i_q_data,
    output logic          o_q_pop,
    mhpq_rsp_if.source    rsp
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = AW + 2;
    localparam int EW = ID_BITS + KEY_BITS;

    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_scr [CAPACITY];
    logic [EW-1:0] r_mem_rd, r_scr_rd;

    t_state              r_st, n_st;
    t_action             r_act, n_act;
    t_status             r_ost, n_ost;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_size, n_size;
    logic [CW-1:0]       r_i, n_i;
    logic                r_ck, n_ck;
    logic                r_moved, n_moved;
    logic                r_list, n_list;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_bigp, n_bigp;
    logic [EW-1:0]       r_cur, n_cur;
    logic [EW-1:0]       r_big, n_big;

    logic                r_ov, n_ov;
    t_status             r_ostat, n_ostat;
    logic [ID_BITS-1:0]  r_oid, n_oid;
    logic [KEY_BITS-1:0] r_okey, n_okey;
    logic                r_oval, n_oval;
    logic [5:0]          r_ocnt, n_ocnt;
    logic                r_olast, n_olast;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          wr_scr;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [PW-1:0] parent, left, right;
    logic          out_free;
    t_action       q_act;
    logic          take_r;
    logic [EW-1:0] big_e;
    logic [PW-1:0] big_p;

    assign rd_data  = r_list ? r_scr_rd : r_mem_rd;
    assign parent   = (r_pos - PW'(1)) >> 1;
    assign left     = {r_pos[PW-2:0], 1'b1};
    assign right    = left + PW'(1);
    assign out_free = !r_ov || rsp.ready;
    assign q_act    = t_action'(i_q_data[QW-1:QW-2]);
    assign take_r   = (right < PW'(r_size)) &&
                      (rd_data[KEY_BITS-1:0] > r_big[KEY_BITS-1:0]);
    assign big_e    = take_r ? rd_data : r_big;
    assign big_p    = take_r ? right : r_bigp;

    assign rsp.valid       = r_ov;
    assign rsp.status      = r_ostat;
    assign rsp.out_id      = r_oid;
    assign rsp.out_key     = r_okey;
    assign rsp.out_valid   = r_oval;
    assign rsp.entry_count = r_ocnt;
    assign rsp.last        = r_olast;

    // one read and one write per memory per cycle; read data is registered
    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_scr) r_mem[wr_addr] <= wr_data;
        if (wr_en && wr_scr)  r_scr[wr_addr] <= wr_data;
        r_mem_rd <= r_mem[rd_addr];
        r_scr_rd <= r_scr[rd_addr];
    end

    // heap walk keeps a hole at r_pos; r_cur is the entry placed at the end
    always_comb begin
        n_st     = r_st;
        n_act    = r_act;
        n_ost    = r_ost;
        n_id     = r_id;
        n_key    = r_key;
        n_fill   = r_fill;
        n_size   = r_size;
        n_i      = r_i;
        n_ck     = r_ck;
        n_moved  = r_moved;
        n_list   = r_list;
        n_pos    = r_pos;
        n_bigp   = r_bigp;
        n_cur    = r_cur;
        n_big    = r_big;
        n_ov     = r_ov && !rsp.ready;
        n_ostat  = r_ostat;
        n_oid    = r_oid;
        n_okey   = r_okey;
        n_oval   = r_oval;
        n_ocnt   = r_ocnt;
        n_olast  = r_olast;
        o_q_pop  = 1'b0;
        rd_addr  = AW'(r_i);
        wr_en    = 1'b0;
        wr_scr   = r_list;
        wr_addr  = r_pos[AW-1:0];
        wr_data  = r_cur;
        case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_act   = q_act;
                    n_id    = i_q_data[EW-1:KEY_BITS];
                    n_key   = i_q_data[KEY_BITS-1:0];
                    n_i     = '0;
                    n_ck    = 1'b0;
                    n_list  = 1'b0;
                    n_moved = 1'b0;
                    n_ost   = ST_OK;
                    case (q_act)
                        ACT_INSERT: begin
                            if (r_fill >= CW'(CAPACITY)) begin
                                n_ost = ST_FULL;
                                n_st  = S_RESULT;
                            end else begin
                                n_cur  = i_q_data[EW-1:0];
                                n_pos  = PW'(r_fill);
                                n_fill = r_fill + 1'b1;
                                n_st   = S_UP_RD;
                            end
                        end
                        ACT_DELETE: n_st = S_FIND;
                        ACT_INCR:   n_st = S_FIND;
                        ACT_LIST: begin
                            n_size = r_fill;
                            n_st   = (r_fill == '0) ? S_RESULT : S_COPY;
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                rd_addr = AW'(r_i);
                if (r_ck && r_mem_rd[EW-1:KEY_BITS] == r_id) begin
                    n_pos = PW'(r_i - 1'b1);
                    n_ck  = 1'b0;
                    if (r_act == ACT_INCR) begin
                        if (r_key < r_mem_rd[KEY_BITS-1:0]) begin
                            n_ost = ST_KEY_LOWER;
                            n_st  = S_RESULT;
                        end else begin
                            n_cur = {r_id, r_key};
                            n_st  = S_UP_RD;
                        end
                    end else begin
                        n_st = S_DEL_RD;
                    end
                end else if (r_i == r_fill) begin
                    n_ost = ST_NOT_FOUND;
                    n_st  = S_RESULT;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_ck = 1'b1;
                end
            end
            S_DEL_RD: begin
                rd_addr = AW'(r_fill - 1'b1);
                n_st    = S_DEL_LD;
            end
            S_DEL_LD: begin
                n_cur   = r_mem_rd;
                n_fill  = r_fill - 1'b1;
                n_size  = r_fill - 1'b1;
                n_moved = 1'b0;
                n_st    = (r_pos == PW'(r_fill - 1'b1)) ? S_RESULT : S_DN_RDL;
            end
            S_UP_RD: begin
                rd_addr = parent[AW-1:0];
                n_st    = (r_pos == '0) ? S_WR : S_UP_CMP;
            end
            S_UP_CMP: begin
                if (rd_data[KEY_BITS-1:0] >= r_cur[KEY_BITS-1:0]) begin
                    n_st = S_WR;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_pos   = parent;
                    n_st    = S_UP_RD;
                end
            end
            S_DN_RDL: begin
                rd_addr = left[AW-1:0];
                n_st    = S_DN_RDR;
            end
            S_DN_RDR: begin
                rd_addr = right[AW-1:0];
                n_big   = r_cur;
                n_bigp  = r_pos;
                if (left < PW'(r_size) &&
                    rd_data[KEY_BITS-1:0] > r_cur[KEY_BITS-1:0]) begin
                    n_big  = rd_data;
                    n_bigp = left;
                end
                n_st = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (big_p == r_pos) begin
                    // an entry that moved down cannot rise above its old slot
                    n_st = (r_moved || r_list) ? S_WR : S_UP_RD;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = big_e;
                    n_pos   = big_p;
                    n_moved = 1'b1;
                    n_st    = S_DN_RDL;
                end
            end
            S_WR: begin
                wr_en = 1'b1;
                n_st  = r_list ? S_EM_RD0 : S_RESULT;
            end
            S_COPY: begin
                rd_addr = AW'(r_i);
                if (r_ck) begin
                    wr_en   = 1'b1;
                    wr_scr  = 1'b1;
                    wr_addr = AW'(r_i - 1'b1);
                    wr_data = r_mem_rd;
                end
                if (r_i == r_size) begin
                    n_list = 1'b1;
                    n_st   = S_EM_RD0;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_ck = 1'b1;
                end
            end
            S_EM_RD0: begin
                rd_addr = '0;
                n_st    = S_EM_RDL;
            end
            S_EM_RDL: begin
                rd_addr = AW'(r_size - 1'b1);
                n_big   = rd_data;
                n_st    = S_EM_OUT;
            end
            S_EM_OUT: begin
                rd_addr = AW'(r_size - 1'b1);
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_OK;
                    n_oid   = r_big[EW-1:KEY_BITS];
                    n_okey  = r_big[KEY_BITS-1:0];
                    n_oval  = 1'b1;
                    n_ocnt  = 6'(r_fill);
                    n_olast = (r_size == CW'(1));
                    n_size  = r_size - 1'b1;
                    n_cur   = rd_data;
                    n_pos   = '0;
                    if (r_size == CW'(1)) begin
                        n_list = 1'b0;
                        n_st   = S_IDLE;
                    end else begin
                        n_st = S_DN_RDL;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ostat = r_ost;
                    n_oid   = '0;
                    n_okey  = '0;
                    n_oval  = 1'b0;
                    n_ocnt  = 6'(r_fill);
                    n_olast = 1'b1;
                    n_st    = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_fill <= '0;
            r_list <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_fill <= n_fill;
            r_list <= n_list;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_ost   <= n_ost;
        r_id    <= n_id;
        r_key   <= n_key;
        r_size  <= n_size;
        r_i     <= n_i;
        r_ck    <= n_ck;
        r_moved <= n_moved;
        r_pos   <= n_pos;
        r_bigp  <= n_bigp;
        r_cur   <= n_cur;
        r_big   <= n_big;
        r_ostat <= n_ostat;
        r_oid   <= n_oid;
        r_okey  <= n_okey;
        r_oval  <= n_oval;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
    end
endmodule

// File: hw/rtl/max_heap_priority_queue_top.sv
// An accepted request is registered in the request queue before the sequencer pops it.
// Insert: sift-up from the new last slot. Delete/increase: id scan over the entries,
// then sift-down (delete only) and sift-up of the entry placed in the hole.
// List: copies the heap to a scratch memory, then extracts the maximum for each result.
// The sequencer takes one request at a time; a 2-entry request queue decouples input.
// Synchronous active-low reset empties the heap, the queue and the result register.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 32,
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);
    import mhpq_pkg::*;

    localparam int QW = 2 + ID_BITS + KEY_BITS;
    logic          q_valid, q_pop;
    logic [QW-1:0] q_data;

    mhpq_front #(.ID_BITS(ID_BITS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(i_req),
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop)
    );

    mhpq_back #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_data(q_data),
        .o_q_pop(q_pop), .rsp(o_rsp)
    );
endmodule

// File: sim/tb_top.sv
module tb_top;
    import mhpq_pkg::*;

    localparam int CAP      = 32;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 32;
    localparam int MAX_CYC  = 500000;

    typedef struct packed {
        t_action          action;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  out_id;
        logic [KEY_W-1:0] out_key;
        logic             out_valid;
        logic [5:0]       entry_count;
        logic             last;
    } rsp_t;

    logic i_clk;
    logic i_rst_n;

    mhpq_req_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W)) req_if ();
    mhpq_rsp_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W)) rsp_if ();

    max_heap_priority_queue_top #(.CAPACITY(CAP), .ID_BITS(ID_W), .KEY_BITS(KEY_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // predictor state
    logic [ID_W-1:0]  hp_ids [CAP];
    logic [KEY_W-1:0] hp_keys[CAP];
    int               hp_fill = 0;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   cycles = 0;
    bit   hold_send = 1'b0;
    bit   req_acc = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_req(req_t q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic void add_rsp(rsp_t r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    task automatic swap_ent(ref logic [ID_W-1:0] ids[CAP], ref logic [KEY_W-1:0] keys[CAP],
                            input int a, input int b);
        logic [ID_W-1:0]  ti;
        logic [KEY_W-1:0] tk;
        ti = ids[a]; ids[a] = ids[b]; ids[b] = ti;
        tk = keys[a]; keys[a] = keys[b]; keys[b] = tk;
    endtask

    task automatic heap_up(ref logic [ID_W-1:0] ids[CAP], ref logic [KEY_W-1:0] keys[CAP],
                           input int pos);
        int par;
        while (pos > 0) begin
            par = (pos - 1) / 2;
            if (keys[par] >= keys[pos]) break;
            swap_ent(ids, keys, par, pos);
            pos = par;
        end
    endtask

    task automatic heap_down(ref logic [ID_W-1:0] ids[CAP], ref logic [KEY_W-1:0] keys[CAP],
                             input int size, input int pos);
        int l;
        int r;
        int big;
        forever begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            big = pos;
            if (l < size && keys[l] > keys[big]) big = l;
            if (r < size && keys[r] > keys[big]) big = r;
            if (big == pos) break;
            swap_ent(ids, keys, pos, big);
            pos = big;
        end
    endtask

    function automatic rsp_t mk_rsp(t_status st, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                                    logic v, logic lst);
        rsp_t r;
        r.status = st;
        r.out_id = id;
        r.out_key = key;
        r.out_valid = v;
        r.entry_count = hp_fill[5:0];
        r.last = lst;
        return r;
    endfunction

    task automatic predict_heap_op(req_t q);
        logic [ID_W-1:0]  sc_ids [CAP];
        logic [KEY_W-1:0] sc_keys[CAP];
        t_status          st;
        int               pos;
        int               size;
        logic [ID_W-1:0]  rid;
        logic [KEY_W-1:0] rkey;
        st = ST_OK;
        pos = -1;
        if (q.action == ACT_DELETE || q.action == ACT_INCR) begin
            for (int i = 0; i < hp_fill; i++) begin
                if (hp_ids[i] == q.id) begin
                    pos = i;
                    break;
                end
            end
        end
        case (q.action)
            ACT_INSERT: begin
                if (hp_fill >= CAP) begin
                    st = ST_FULL;
                end else begin
                    hp_ids[hp_fill] = q.id;
                    hp_keys[hp_fill] = q.key;
                    hp_fill++;
                    heap_up(hp_ids, hp_keys, hp_fill - 1);
                end
            end
            ACT_DELETE: begin
                if (pos < 0) begin
                    st = ST_NOT_FOUND;
                end else begin
                    swap_ent(hp_ids, hp_keys, pos, hp_fill - 1);
                    hp_fill--;
                    if (pos < hp_fill) begin
                        heap_down(hp_ids, hp_keys, hp_fill, pos);
                        heap_up(hp_ids, hp_keys, pos);
                    end
                end
            end
            ACT_INCR: begin
                if (pos < 0) begin
                    st = ST_NOT_FOUND;
                end else if (q.key < hp_keys[pos]) begin
                    st = ST_KEY_LOWER;
                end else begin
                    hp_keys[pos] = q.key;
                    heap_up(hp_ids, hp_keys, pos);
                end
            end
            default: begin
                size = hp_fill;
                if (size == 0) begin
                    add_rsp(mk_rsp(ST_OK, '0, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < size; i++) begin
                        sc_ids[i] = hp_ids[i];
                        sc_keys[i] = hp_keys[i];
                    end
                    while (size > 0) begin
                        rid = sc_ids[0];
                        rkey = sc_keys[0];
                        size--;
                        sc_ids[0] = sc_ids[size];
                        sc_keys[0] = sc_keys[size];
                        heap_down(sc_ids, sc_keys, size, 0);
                        add_rsp(mk_rsp(ST_OK, rid, rkey, 1'b1, size == 0));
                    end
                end
                return;
            end
        endcase
        add_rsp(mk_rsp(st, '0, '0, 1'b0, 1'b1));
    endtask

    function automatic req_t mk_req(t_action a, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        req_t q;
        q.action = a;
        q.id = id;
        q.key = key;
        return q;
    endfunction

    // request monitor: predicts at the accepting edge
    always @(posedge i_clk) begin
        req_acc <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_heap_op(mk_req(t_action'(req_if.action), req_if.item_id,
                                   req_if.item_key));
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_acc) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_send) begin
                req_t q;
                q = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.action <= q.action;
                req_if.item_id <= q.id;
                req_if.item_key <= q.key;
                send_gap <= pick_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_gap <= pick_gap();
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_t g;
            rsp_t e;
            g.status = t_status'(rsp_if.status);
            g.out_id = rsp_if.out_id;
            g.out_key = rsp_if.out_key;
            g.out_valid = rsp_if.out_valid;
            g.entry_count = rsp_if.entry_count;
            g.last = rsp_if.last;
            if (expected_rsps.size() == 0) begin
                $error("unexpected response");
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (g.status !== e.status)
                    $error("status expected %0d actual %0d", e.status, g.status);
                if (g.out_id !== e.out_id)
                    $error("out_id expected %0h actual %0h", e.out_id, g.out_id);
                if (g.out_key !== e.out_key)
                    $error("out_key expected %0h actual %0h", e.out_key, g.out_key);
                if (g.out_valid !== e.out_valid)
                    $error("out_valid expected %0d actual %0d", e.out_valid, g.out_valid);
                if (g.entry_count !== e.entry_count)
                    $error("entry_count expected %0d actual %0d", e.entry_count,
                           g.entry_count);
                if (g.last !== e.last)
                    $error("last expected %0d actual %0d", e.last, g.last);
                if (g != e) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] rand_id(int pool);
        if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
        return ID_W'($urandom_range(0, pool));
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom);
    endfunction

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int r;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        add_req(mk_req(ACT_LIST, 16'h0, 32'h0));
        add_req(mk_req(ACT_DELETE, 16'h5, 32'h0));
        add_req(mk_req(ACT_INCR, 16'h5, 32'h9));
        add_req(mk_req(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
        add_req(mk_req(ACT_INSERT, 16'h0000, 32'h0));
        add_req(mk_req(ACT_INSERT, 16'h0007, 32'h5));
        add_req(mk_req(ACT_INSERT, 16'h0007, 32'h5));
        add_req(mk_req(ACT_INCR, 16'h0000, 32'h5));
        add_req(mk_req(ACT_INCR, 16'h0007, 32'h5));
        add_req(mk_req(ACT_INCR, 16'h0007, 32'h1));
        add_req(mk_req(ACT_LIST, 16'hAAAA, 32'h5555_5555));
        add_req(mk_req(ACT_DELETE, 16'hFFFF, 32'h0));
        add_req(mk_req(ACT_DELETE, 16'h0007, 32'h0));
        add_req(mk_req(ACT_LIST, 16'h0, 32'h0));
        wait_drain();
        for (int i = 0; i < CAP + 1; i++)
            add_req(mk_req(ACT_INSERT, ID_W'(i), KEY_W'($urandom_range(0, 7))));
        add_req(mk_req(ACT_LIST, 16'h0, 32'h0));
        wait_drain();

        for (int i = 0; i < 6; i++)
            add_req(mk_req(ACT_DELETE, ID_W'(i * 3), 32'h0));
        add_req(mk_req(ACT_LIST, 16'h0, 32'h0));

        // random
        for (int n = 0; n < 100; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                add_req(mk_req(ACT_INSERT, rand_id(40), rand_key()));
            else if (r < 60)
                add_req(mk_req(ACT_DELETE, rand_id(40), rand_key()));
            else if (r < 88)
                add_req(mk_req(ACT_INCR, rand_id(40), rand_key()));
            else
                add_req(mk_req(ACT_LIST, ID_W'($urandom), KEY_W'($urandom)));
            if (n == 50) begin
                // pause sender until everything has returned
                wait_drain();
                hold_send = 1;
                repeat (50) @(posedge i_clk);
                hold_send = 0;
            end
        end
        wait_drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
